FILE: hw/rtl/apc_pkg.sv
// Shared types and constants for the arm position drive.
// Payload structs, command codes, register indexes and fixed arithmetic constants.
// No dependencies.
`timescale 1ns / 1ps

package apc_pkg;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_BRAKE = 2'd2
    } cmd_t;

    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [2:0] REG_MANUAL_SPEED = 3'd0;
    localparam logic [2:0] REG_GAIN         = 3'd1;
    localparam logic [2:0] REG_REST_ANGLE   = 3'd2;
    localparam logic [2:0] REG_LOAD_ANGLE   = 3'd3;
    localparam logic [2:0] REG_SHOOT_ANGLE  = 3'd4;
    localparam logic [2:0] REG_STAKE_ANGLE  = 3'd5;

    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned ANGLE_W = 9;

    // ceil(2^23 / 100): exact floor(x / 100) for every 16-bit x
    localparam logic [16:0] DIV100_MUL   = 17'd83887;
    localparam int unsigned DIV100_SHIFT = 23;

    localparam logic [ANGLE_W-1:0] WIN_LO = 9'd130;
    localparam logic [ANGLE_W-1:0] WIN_HI = 9'd210;

    typedef struct packed {
        logic        func;
        logic        btn_up;
        logic        btn_down;
        logic        btn_rest;
        logic        btn_load;
        logic        btn_shoot;
        logic        btn_stake;
        logic [15:0] angle_centideg;
    } in_t;

    typedef struct packed {
        cmd_t              command;
        logic signed [7:0] motor_power;
        logic              auto_active;
    } out_t;

    typedef struct packed {
        logic [6:0]         manual_speed;
        logic [15:0]        gain_q8_8;
        logic [ANGLE_W-1:0] rest_angle;
        logic [ANGLE_W-1:0] load_angle;
        logic [ANGLE_W-1:0] shoot_angle;
        logic [ANGLE_W-1:0] stake_angle;
    } cfg_t;

    // input stage: buttons plus sensor angle already in whole degrees
    typedef struct packed {
        logic             func;
        logic             btn_up;
        logic             btn_down;
        logic             btn_rest;
        logic             btn_load;
        logic             btn_shoot;
        logic             btn_stake;
        logic [POS_W-1:0] pos;
    } stage_t;

endpackage

FILE: hw/rtl/apc_regs.sv
// APB configuration registers of the arm position drive.
// Depends on apc_pkg.
`timescale 1ns / 1ps

module apc_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [apc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output apc_pkg::cfg_t              cfg
);
    import apc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.manual_speed <= 7'd127;
            cfg_reg.gain_q8_8    <= 16'd256;
            cfg_reg.rest_angle   <= '0;
            cfg_reg.load_angle   <= '0;
            cfg_reg.shoot_angle  <= '0;
            cfg_reg.stake_angle  <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_MANUAL_SPEED: cfg_reg.manual_speed <= pwdata[6:0];
                REG_GAIN:         cfg_reg.gain_q8_8    <= pwdata[15:0];
                REG_REST_ANGLE:   cfg_reg.rest_angle   <= pwdata[ANGLE_W-1:0];
                REG_LOAD_ANGLE:   cfg_reg.load_angle   <= pwdata[ANGLE_W-1:0];
                REG_SHOOT_ANGLE:  cfg_reg.shoot_angle  <= pwdata[ANGLE_W-1:0];
                REG_STAKE_ANGLE:  cfg_reg.stake_angle  <= pwdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_MANUAL_SPEED: prdata = {25'd0, cfg_reg.manual_speed};
            REG_GAIN:         prdata = {16'd0, cfg_reg.gain_q8_8};
            REG_REST_ANGLE:   prdata = {23'd0, cfg_reg.rest_angle};
            REG_LOAD_ANGLE:   prdata = {23'd0, cfg_reg.load_angle};
            REG_SHOOT_ANGLE:  prdata = {23'd0, cfg_reg.shoot_angle};
            REG_STAKE_ANGLE:  prdata = {23'd0, cfg_reg.stake_angle};
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/apc_prop.sv
// Proportional power on the wrapped angle error, with window override and clamp.
// Depends on apc_pkg.
`timescale 1ns / 1ps

module apc_prop (
    input  logic [apc_pkg::POS_W-1:0]   pos,
    input  logic [apc_pkg::ANGLE_W-1:0] target,
    input  logic [15:0]                 gain_q8_8,
    output logic signed [7:0]           power
);
    import apc_pkg::*;

    logic signed [10:0] diff;
    logic signed [10:0] wrapped;
    logic signed [8:0]  err;
    logic signed [25:0] prod;
    logic signed [17:0] quot;
    logic signed [17:0] shaped;
    logic               pos_in_win;
    logic               tgt_in_win;

    assign pos_in_win = ({1'b0, WIN_LO} < pos) && (pos < {1'b0, WIN_HI});
    assign tgt_in_win = (WIN_LO < target) && (target < WIN_HI);

    // diff spans -475..691, so one correction step lands in 0..359
    assign diff = $signed({2'b00, target}) - $signed({1'b0, pos}) + 11'sd180;

    always_comb begin
        priority if (diff < -11'sd360) begin
            wrapped = diff + 11'sd720;
        end else if (diff < 11'sd0) begin
            wrapped = diff + 11'sd360;
        end else if (diff >= 11'sd360) begin
            wrapped = diff - 11'sd360;
        end else begin
            wrapped = diff;
        end
    end

    assign err  = 9'sd180 - wrapped[8:0];
    assign prod = 26'(err) * 26'($signed({1'b0, gain_q8_8}));

    // divide by 256 rounding toward zero
    always_comb begin
        if (prod < 0) begin
            quot = 18'((prod + 26'sd255) >>> 8);
        end else begin
            quot = 18'(prod >>> 8);
        end
    end

    always_comb begin
        shaped = quot;
        if (pos_in_win && !tgt_in_win && quot > 0) begin
            shaped = -quot;
        end
    end

    always_comb begin
        priority if (shaped > 18'sd127) begin
            power = 8'sd127;
        end else if (shaped < -18'sd127) begin
            power = -8'sd127;
        end else begin
            power = shaped[7:0];
        end
    end

endmodule

FILE: hw/rtl/arm_position_p_controller.sv
// Arm position drive: manual up/down drive, brake, and four preset targets held
// by a proportional loop on the wrapped angle error. Every input transfer gives
// exactly one result transfer. An item passes an input register (where the
// sensor angle is already reduced to whole degrees) and one pass of logic into
// the result register, and one item is taken every cycle; the only stalls come
// from m_ready held low. Registers sit on an APB port at 4*index and should be
// written while no transfer is in flight.
`timescale 1ns / 1ps

module arm_position_p_controller (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  apc_pkg::in_t               s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output apc_pkg::out_t              m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [apc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import apc_pkg::*;

    cfg_t               cfg;
    logic [32:0]        div_prod;
    stage_t             in_next;
    stage_t             in_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    out_t               out_reg;
    out_t               out_next;
    logic [ANGLE_W-1:0] target_reg;
    logic [ANGLE_W-1:0] target_next;
    logic               auto_reg;
    logic               auto_next;
    logic               out_free;
    logic               advance;
    logic signed [7:0]  tick_power;

    apc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    apc_prop u_prop (
        .pos       (in_reg.pos),
        .target    (target_reg),
        .gain_q8_8 (cfg.gain_q8_8),
        .power     (tick_power)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // whole degrees via reciprocal multiply
    assign div_prod = {17'd0, s_data.angle_centideg} * {16'd0, DIV100_MUL};

    always_comb begin
        in_next.func      = s_data.func;
        in_next.btn_up    = s_data.btn_up;
        in_next.btn_down  = s_data.btn_down;
        in_next.btn_rest  = s_data.btn_rest;
        in_next.btn_load  = s_data.btn_load;
        in_next.btn_shoot = s_data.btn_shoot;
        in_next.btn_stake = s_data.btn_stake;
        in_next.pos       = div_prod[DIV100_SHIFT +: POS_W];
    end

    always_comb begin
        target_next          = target_reg;
        auto_next            = auto_reg;
        out_next.command     = CMD_NONE;
        out_next.motor_power = '0;
        if (in_reg.func == FUNC_POLL) begin
            if (in_reg.btn_up) begin
                out_next.command     = CMD_MOVE;
                out_next.motor_power = $signed({1'b0, cfg.manual_speed});
                auto_next            = 1'b0;
            end else if (in_reg.btn_down) begin
                out_next.command     = CMD_MOVE;
                out_next.motor_power = -$signed({1'b0, cfg.manual_speed});
                auto_next            = 1'b0;
            end else if (!auto_reg) begin
                out_next.command = CMD_BRAKE;
            end
            // later presets override earlier ones
            if (in_reg.btn_rest) begin
                target_next = cfg.rest_angle;
                auto_next   = 1'b1;
            end
            if (in_reg.btn_load) begin
                target_next = cfg.load_angle;
                auto_next   = 1'b1;
            end
            if (in_reg.btn_shoot) begin
                target_next = cfg.shoot_angle;
                auto_next   = 1'b1;
            end
            if (in_reg.btn_stake) begin
                target_next = cfg.stake_angle;
                auto_next   = 1'b1;
            end
        end else if (auto_reg) begin
            out_next.command     = CMD_MOVE;
            out_next.motor_power = tick_power;
        end
        out_next.auto_active = auto_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
            auto_reg      <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                target_reg    <= target_next;
                auto_reg      <= auto_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= in_next;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: hw/rtl/apc_checker.sv
// Port-level checks for the arm position drive, bound to the top level.
// Depends on apc_pkg and arm_position_p_controller.
`timescale 1ns / 1ps

module apc_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input apc_pkg::out_t m_data
);
    import apc_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_stall_only_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    a_power_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.motor_power != -8'sd128 &&
                    (m_data.command == CMD_MOVE || m_data.motor_power == 8'sd0))
        else $error("power outside clamp or set without move");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind arm_position_p_controller apc_checker u_apc_checker (.*);
